FILE: sv/buddy_block_allocator_core_macros.svh
// ---------------------------------------------------------------------------
// buddy block allocator assertion macros
// shared property forms for the allocator core checks
// ---------------------------------------------------------------------------
`ifndef BUDDY_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define BBA_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator check failed");

// expression never true
`define BBA_ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("allocator check failed");

`endif

FILE: sv/bba_pkg.sv
// ---------------------------------------------------------------------------
// buddy block allocator package
// fixed widths and block table kind codes
// ---------------------------------------------------------------------------
package bba_pkg;

  localparam int DATA_W  = 16;
  localparam int LEVEL_W = 5;
  localparam int TOT_W   = 17;

  typedef enum logic [1:0] {
    KIND_UNUSED = 2'd0,
    KIND_FREE   = 2'd1,
    KIND_ALLOC  = 2'd2
  } kind_t;

endpackage

FILE: sv/bba_ram.sv
// ---------------------------------------------------------------------------
// bba ram
// generic simple dual port ram, one write port, one registered read port
// ---------------------------------------------------------------------------
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/buddy_block_allocator_core.sv
// ---------------------------------------------------------------------------
// buddy block allocator core
// binary buddy allocator with its block table in one synchronous ram
// ---------------------------------------------------------------------------
// input channel: in_valid/in_stall with mode, request_bytes, data_address.
// mode 0 allocates request_bytes plus a header, mode 1 frees data_address.
// output channel: out_valid/out_stall with address and success, exactly
// one result per input transfer, in order.
// after reset a clearing pass walks all 2^(LOG_MEMORY_BYTES - min level)
// table entries (1024 at the defaults), one entry a cycle, with
// in_stall high; entry 0 then holds the single free top level block.
// one item is worked at a time; in_stall is low only while idle.
// allocate: size the target level, take the head of the lowest non-empty
// list at or above it (fixing its successor), then split down, pushing each
// upper half (fixing the old list head), and mark the block allocated.
// free: check the address and its entry, merge while the buddy is free at
// that level, then push. each table read modify write is a read then write.
// the result sits in an output register; a new item is taken while it
// waits, and the core holds a finished result while out_stall is high.
// ---------------------------------------------------------------------------
`include "buddy_block_allocator_core_macros.svh"

module buddy_block_allocator_core #(
  parameter int LOG_MEMORY_BYTES = 16,
  parameter int HEADER_BYTES     = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      mode,
  input  logic [bba_pkg::DATA_W-1:0] request_bytes,
  input  logic [bba_pkg::DATA_W-1:0] data_address,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [bba_pkg::DATA_W-1:0] address,
  output logic                      success
);

  localparam int MIN_LEVEL = (HEADER_BYTES < 2) ? 1 : (HEADER_BYTES < 4) ? 2 :
                             (HEADER_BYTES < 8) ? 3 : (HEADER_BYTES < 16) ? 4 :
                             (HEADER_BYTES < 32) ? 5 : (HEADER_BYTES < 64) ? 6 :
                             (HEADER_BYTES < 128) ? 7 : (HEADER_BYTES < 256) ? 8 : 9;
  localparam int TABLE_LOG  = (LOG_MEMORY_BYTES > MIN_LEVEL) ?
                              (LOG_MEMORY_BYTES - MIN_LEVEL) : 0;
  localparam int DEPTH      = 1 << TABLE_LOG;
  localparam int TIW        = (TABLE_LOG > 0) ? TABLE_LOG : 1;
  localparam int NUM_LEVELS = LOG_MEMORY_BYTES + 1;
  localparam int LVW        = $clog2(NUM_LEVELS);
  localparam int LW         = bba_pkg::LEVEL_W;

  typedef struct packed {
    bba_pkg::kind_t  kind;
    logic [LW-1:0]   level;
    logic            has_next;
    logic            has_prev;
    logic [TIW-1:0]  next;
    logic [TIW-1:0]  prev;
  } entry_t;

  localparam int EW = $bits(entry_t);

  typedef enum logic [17:0] {
    ST_CLEAR    = 18'h00001,
    ST_IDLE     = 18'h00002,
    ST_A_CALC   = 18'h00004,
    ST_A_FIND   = 18'h00008,
    ST_A_UNLINK = 18'h00010,
    ST_A_NFIX   = 18'h00020,
    ST_SPLIT    = 18'h00040,
    ST_PUSH     = 18'h00080,
    ST_P_FIX    = 18'h00100,
    ST_F_CHK    = 18'h00200,
    ST_F_ENT    = 18'h00400,
    ST_MERGE    = 18'h00800,
    ST_M_BUD    = 18'h01000,
    ST_U_PW     = 18'h02000,
    ST_U_NX     = 18'h04000,
    ST_U_NW     = 18'h08000,
    ST_U_END    = 18'h10000,
    ST_RESP     = 18'h20000
  } state_t;

  function automatic logic [TIW-1:0] lvl_bit(input logic [LW-1:0] lv);
    lvl_bit = TIW'(1) << (lv - LW'(MIN_LEVEL));
  endfunction

  state_t state, state_next;

  logic                       mode_q, mode_q_next;
  logic [bba_pkg::DATA_W-1:0] req_q, req_q_next;
  logic [bba_pkg::DATA_W-1:0] addr_q, addr_q_next;
  logic [LW-1:0]              target, target_next;
  logic [LW-1:0]              lvl, lvl_next;
  logic [TIW-1:0]             idx, idx_next;
  logic [TIW-1:0]             push_idx, push_idx_next;
  logic [LW-1:0]              push_lv, push_lv_next;
  logic [TIW-1:0]             fix_addr, fix_addr_next;
  logic [TIW-1:0]             b_next, b_next_next;
  logic [TIW-1:0]             b_prev, b_prev_next;
  logic                       b_hn, b_hn_next;
  logic                       b_hp, b_hp_next;
  logic                       res_ok, res_ok_next;
  logic [bba_pkg::DATA_W-1:0] res_addr, res_addr_next;
  logic [NUM_LEVELS-1:0]      hv, hv_next;
  logic [TIW-1:0]             heads [NUM_LEVELS];
  logic [TIW-1:0]             heads_next [NUM_LEVELS];
  logic [TIW-1:0]             clr, clr_next;
  logic                       out_valid_next;
  logic [bba_pkg::DATA_W-1:0] address_next;
  logic                       success_next;

  logic            ram_we;
  logic            ram_re;
  logic [TIW-1:0]  ram_waddr;
  logic [TIW-1:0]  ram_raddr;
  entry_t          ram_wdata;
  entry_t          rd;
  logic [EW-1:0]   ram_rdata;

  logic [bba_pkg::TOT_W-1:0] tot_m1;
  logic [LW-1:0]             t_calc;
  logic [LW-1:0]             lv_found;
  logic                      found;
  logic [31:0]               a32;
  logic [31:0]               off32;
  logic [31:0]               slot32;
  logic                      free_bad;
  logic [LVW-1:0]            li;
  logic [LVW-1:0]            pli;

  assign rd = entry_t'(ram_rdata);
  assign li = lvl[LVW-1:0];
  assign pli = push_lv[LVW-1:0];
  assign in_stall = (state != ST_IDLE);

  always_comb begin
    tot_m1 = bba_pkg::TOT_W'(req_q) + bba_pkg::TOT_W'(HEADER_BYTES) - bba_pkg::TOT_W'(1);
    t_calc = '0;
    for (int i = 0; i < bba_pkg::TOT_W; i++) begin
      if (tot_m1[i]) begin
        t_calc = LW'(i + 1);
      end
    end
  end

  always_comb begin
    found = 1'b0;
    lv_found = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (hv[i] && (LW'(i) >= target)) begin
        found = 1'b1;
        lv_found = LW'(i);
      end
    end
  end

  always_comb begin
    a32 = 32'(addr_q);
    off32 = a32 - 32'(HEADER_BYTES);
    slot32 = off32 >> MIN_LEVEL;
    free_bad = (a32 < 32'(HEADER_BYTES)) || (a32 >= (32'd1 << LOG_MEMORY_BYTES)) ||
               ((off32 & ((32'd1 << MIN_LEVEL) - 32'd1)) != 32'd0) ||
               ((slot32 >> TABLE_LOG) != 32'd0);
  end

  always_comb begin
    state_next = state;
    mode_q_next = mode_q;
    req_q_next = req_q;
    addr_q_next = addr_q;
    target_next = target;
    lvl_next = lvl;
    idx_next = idx;
    push_idx_next = push_idx;
    push_lv_next = push_lv;
    fix_addr_next = fix_addr;
    b_next_next = b_next;
    b_prev_next = b_prev;
    b_hn_next = b_hn;
    b_hp_next = b_hp;
    res_ok_next = res_ok;
    res_addr_next = res_addr;
    hv_next = hv;
    heads_next = heads;
    clr_next = clr;
    out_valid_next = out_valid && out_stall;
    address_next = address;
    success_next = success;
    ram_we = 1'b0;
    ram_re = 1'b0;
    ram_waddr = '0;
    ram_raddr = '0;
    ram_wdata = '0;

    unique case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
        ram_waddr = clr;
        if (clr == '0) begin
          ram_wdata.kind = bba_pkg::KIND_FREE;
          ram_wdata.level = LW'(LOG_MEMORY_BYTES);
        end else begin
          ram_wdata.kind = bba_pkg::KIND_UNUSED;
        end
        clr_next = clr + TIW'(1);
        if (clr == TIW'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          mode_q_next = mode;
          req_q_next = request_bytes;
          addr_q_next = data_address;
          res_ok_next = 1'b0;
          res_addr_next = '0;
          state_next = mode ? ST_F_CHK : ST_A_CALC;
        end
      end
      ST_A_CALC: begin
        target_next = t_calc;
        if ((req_q == '0) || (t_calc > LW'(LOG_MEMORY_BYTES))) begin
          state_next = ST_RESP;
        end else begin
          state_next = ST_A_FIND;
        end
      end
      ST_A_FIND: begin
        if (!found) begin
          state_next = ST_RESP;
        end else begin
          lvl_next = lv_found;
          idx_next = heads[lv_found[LVW-1:0]];
          ram_re = 1'b1;
          ram_raddr = heads[lv_found[LVW-1:0]];
          state_next = ST_A_UNLINK;
        end
      end
      ST_A_UNLINK: begin
        heads_next[li] = rd.next;
        hv_next[li] = rd.has_next;
        if (rd.has_next) begin
          ram_re = 1'b1;
          ram_raddr = rd.next;
          fix_addr_next = rd.next;
          state_next = ST_A_NFIX;
        end else begin
          state_next = ST_SPLIT;
        end
      end
      ST_A_NFIX: begin
        ram_we = 1'b1;
        ram_waddr = fix_addr;
        ram_wdata = rd;
        ram_wdata.has_prev = 1'b0;
        ram_wdata.prev = '0;
        state_next = ST_SPLIT;
      end
      ST_SPLIT: begin
        if (lvl == target) begin
          ram_we = 1'b1;
          ram_waddr = idx;
          ram_wdata.kind = bba_pkg::KIND_ALLOC;
          ram_wdata.level = target;
          res_ok_next = 1'b1;
          res_addr_next = bba_pkg::DATA_W'((32'(idx) << MIN_LEVEL) + 32'(HEADER_BYTES));
          state_next = ST_RESP;
        end else begin
          lvl_next = lvl - LW'(1);
          push_lv_next = lvl - LW'(1);
          push_idx_next = idx | lvl_bit(lvl - LW'(1));
          state_next = ST_PUSH;
        end
      end
      ST_PUSH: begin
        ram_we = 1'b1;
        ram_waddr = push_idx;
        ram_wdata.kind = bba_pkg::KIND_FREE;
        ram_wdata.level = push_lv;
        ram_wdata.has_next = hv[pli];
        ram_wdata.next = heads[pli];
        heads_next[pli] = push_idx;
        hv_next[pli] = 1'b1;
        if (hv[pli]) begin
          ram_re = 1'b1;
          ram_raddr = heads[pli];
          fix_addr_next = heads[pli];
          state_next = ST_P_FIX;
        end else begin
          state_next = mode_q ? ST_RESP : ST_SPLIT;
        end
      end
      ST_P_FIX: begin
        ram_we = 1'b1;
        ram_waddr = fix_addr;
        ram_wdata = rd;
        ram_wdata.has_prev = 1'b1;
        ram_wdata.prev = push_idx;
        state_next = mode_q ? ST_RESP : ST_SPLIT;
      end
      ST_F_CHK: begin
        if (free_bad) begin
          state_next = ST_RESP;
        end else begin
          idx_next = TIW'(slot32);
          ram_re = 1'b1;
          ram_raddr = TIW'(slot32);
          state_next = ST_F_ENT;
        end
      end
      ST_F_ENT: begin
        if ((rd.kind != bba_pkg::KIND_ALLOC) || (rd.level > LW'(LOG_MEMORY_BYTES))) begin
          state_next = ST_RESP;
        end else begin
          lvl_next = rd.level;
          res_ok_next = 1'b1;
          state_next = ST_MERGE;
        end
      end
      ST_MERGE: begin
        if (lvl == LW'(LOG_MEMORY_BYTES)) begin
          push_idx_next = idx;
          push_lv_next = lvl;
          state_next = ST_PUSH;
        end else begin
          ram_re = 1'b1;
          ram_raddr = idx ^ lvl_bit(lvl);
          state_next = ST_M_BUD;
        end
      end
      ST_M_BUD: begin
        if ((rd.kind != bba_pkg::KIND_FREE) || (rd.level != lvl)) begin
          push_idx_next = idx;
          push_lv_next = lvl;
          state_next = ST_PUSH;
        end else begin
          b_next_next = rd.next;
          b_prev_next = rd.prev;
          b_hn_next = rd.has_next;
          b_hp_next = rd.has_prev;
          if (rd.has_prev) begin
            ram_re = 1'b1;
            ram_raddr = rd.prev;
            state_next = ST_U_PW;
          end else begin
            heads_next[li] = rd.next;
            hv_next[li] = rd.has_next;
            state_next = ST_U_NX;
          end
        end
      end
      ST_U_PW: begin
        ram_we = 1'b1;
        ram_waddr = b_prev;
        ram_wdata = rd;
        ram_wdata.has_next = b_hn;
        ram_wdata.next = b_next;
        state_next = ST_U_NX;
      end
      ST_U_NX: begin
        if (b_hn) begin
          ram_re = 1'b1;
          ram_raddr = b_next;
          state_next = ST_U_NW;
        end else begin
          state_next = ST_U_END;
        end
      end
      ST_U_NW: begin
        ram_we = 1'b1;
        ram_waddr = b_next;
        ram_wdata = rd;
        ram_wdata.has_prev = b_hp;
        ram_wdata.prev = b_prev;
        state_next = ST_U_END;
      end
      ST_U_END: begin
        ram_we = 1'b1;
        ram_waddr = idx | lvl_bit(lvl);
        ram_wdata.kind = bba_pkg::KIND_UNUSED;
        ram_wdata.level = lvl;
        idx_next = idx & ~lvl_bit(lvl);
        lvl_next = lvl + LW'(1);
        state_next = ST_MERGE;
      end
      ST_RESP: begin
        if (!out_valid || !out_stall) begin
          out_valid_next = 1'b1;
          address_next = res_addr;
          success_next = res_ok;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr <= '0;
      out_valid <= 1'b0;
      hv <= NUM_LEVELS'(1) << LOG_MEMORY_BYTES;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        heads[i] <= '0;
      end
    end else begin
      state <= state_next;
      clr <= clr_next;
      out_valid <= out_valid_next;
      hv <= hv_next;
      heads <= heads_next;
    end
  end

  always_ff @(posedge clk) begin
    mode_q <= mode_q_next;
    req_q <= req_q_next;
    addr_q <= addr_q_next;
    target <= target_next;
    lvl <= lvl_next;
    idx <= idx_next;
    push_idx <= push_idx_next;
    push_lv <= push_lv_next;
    fix_addr <= fix_addr_next;
    b_next <= b_next_next;
    b_prev <= b_prev_next;
    b_hn <= b_hn_next;
    b_hp <= b_hp_next;
    res_ok <= res_ok_next;
    res_addr <= res_addr_next;
    address <= address_next;
    success <= success_next;
  end

  bba_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  `BBA_ASSERT_IMPL(a_fail_zero, clk, rst, out_valid && !success, address == '0)
  `BBA_ASSERT_NEVER(a_rw_same, clk, rst, ram_we && ram_re && (ram_waddr == ram_raddr))
  `BBA_ASSERT_IMPL(a_out_from_resp, clk, rst, $rose(out_valid), $past(state) == ST_RESP)
  `BBA_ASSERT_NEVER(a_low_level, clk, rst, hv[0])

endmodule

FILE: sim/buddy_block_allocator_core_checker.sv
// ---------------------------------------------------------------------------
// buddy block allocator checker
// watches both channels, predicts each result from its own model of the
// block table and free lists, and compares result fields in order
// ---------------------------------------------------------------------------
module buddy_block_allocator_core_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic                       mode,
  input  logic [bba_pkg::DATA_W-1:0] request_bytes,
  input  logic [bba_pkg::DATA_W-1:0] data_address,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [bba_pkg::DATA_W-1:0] address,
  input  logic                       success,
  output int                         errors,
  output int                         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LOG_MEM = 16;
  localparam int HDR     = 32;
  localparam int MIN_LVL = 6;
  localparam int DEPTH   = 1 << (LOG_MEM - MIN_LVL);
  localparam int LEVELS  = LOG_MEM + 1;

  typedef struct packed {
    logic [bba_pkg::DATA_W-1:0] address;
    logic                       success;
  } grant_t;

  bba_pkg::kind_t blk_kind [DEPTH];
  int             blk_lvl  [DEPTH];
  bit             nxt_v    [DEPTH];
  bit             prv_v    [DEPTH];
  int             nxt      [DEPTH];
  int             prv      [DEPTH];
  bit             head_v   [LEVELS];
  int             head     [LEVELS];
  grant_t         grants_due[$];

  assign pending = grants_due.size();

  function automatic void unlink_block(int idx);
    int lv;
    lv = blk_lvl[idx];
    if (lv >= LEVELS) return;
    if (prv_v[idx]) begin
      nxt_v[prv[idx]] = nxt_v[idx];
      nxt[prv[idx]]   = nxt[idx];
    end else begin
      head_v[lv] = nxt_v[idx];
      head[lv]   = nxt[idx];
    end
    if (nxt_v[idx]) begin
      prv_v[nxt[idx]] = prv_v[idx];
      prv[nxt[idx]]   = prv[idx];
    end
    nxt_v[idx] = 0;
    prv_v[idx] = 0;
    nxt[idx]   = 0;
    prv[idx]   = 0;
  endfunction

  function automatic void push_block(int idx, int lv);
    if (lv >= LEVELS) return;
    blk_kind[idx] = bba_pkg::KIND_FREE;
    blk_lvl[idx]  = lv;
    prv_v[idx]    = 0;
    prv[idx]      = 0;
    nxt_v[idx]    = head_v[lv];
    nxt[idx]      = head[lv];
    if (head_v[lv]) begin
      prv_v[head[lv]] = 1;
      prv[head[lv]]   = idx;
    end
    head_v[lv] = 1;
    head[lv]   = idx;
  endfunction

  function automatic grant_t allocate_block(longint req);
    grant_t g;
    int     target;
    int     lv;
    int     idx;
    longint off;
    g = '0;
    target = 0;
    if (req == 0) return g;
    while (target < 40 && (longint'(1) << target) < req + HDR) target++;
    if (target > LOG_MEM) return g;
    lv = target;
    while (lv <= LOG_MEM && !head_v[lv]) lv++;
    if (lv > LOG_MEM) return g;
    idx = head[lv];
    unlink_block(idx);
    off = longint'(idx) << MIN_LVL;
    while (lv > target) begin
      lv--;
      push_block(int'(((off + (longint'(1) << lv)) >> MIN_LVL) % DEPTH), lv);
    end
    blk_kind[idx] = bba_pkg::KIND_ALLOC;
    blk_lvl[idx]  = target;
    g.address = bba_pkg::DATA_W'(off + HDR);
    g.success = 1;
    return g;
  endfunction

  function automatic bit release_block(longint addr);
    longint off;
    longint boff;
    int     idx;
    int     bidx;
    int     lv;
    if (addr < HDR || addr >= (longint'(1) << LOG_MEM)) return 0;
    off = addr - HDR;
    if (off % (1 << MIN_LVL) != 0) return 0;
    idx = int'(off >> MIN_LVL);
    if (blk_kind[idx] != bba_pkg::KIND_ALLOC) return 0;
    lv = blk_lvl[idx];
    while (lv < LOG_MEM) begin
      boff = off ^ (longint'(1) << lv);
      bidx = int'(boff >> MIN_LVL);
      if (blk_kind[bidx] != bba_pkg::KIND_FREE || blk_lvl[bidx] != lv) break;
      unlink_block(bidx);
      blk_kind[bidx] = bba_pkg::KIND_UNUSED;
      blk_kind[idx]  = bba_pkg::KIND_UNUSED;
      if (boff < off) off = boff;
      idx = int'(off >> MIN_LVL);
      lv++;
    end
    push_block(idx, lv);
    return 1;
  endfunction

  always @(posedge clk) begin
    grant_t g;
    int     errs;
    errs = 0;
    if (rst) begin
      errors <= 0;
      grants_due.delete();
      for (int i = 0; i < DEPTH; i++) begin
        blk_kind[i] = bba_pkg::KIND_UNUSED;
        blk_lvl[i]  = 0;
        nxt_v[i]    = 0;
        prv_v[i]    = 0;
        nxt[i]      = 0;
        prv[i]      = 0;
      end
      for (int l = 0; l < LEVELS; l++) begin
        head_v[l] = 0;
        head[l]   = 0;
      end
      blk_kind[0]     = bba_pkg::KIND_FREE;
      blk_lvl[0]      = LOG_MEM;
      head_v[LOG_MEM] = 1;
    end else begin
      if (out_valid && !out_stall) begin
        if (grants_due.size() == 0) begin
          $error("unexpected result transfer: address %0d success %0d", address, success);
          errs++;
        end else begin
          g = grants_due.pop_front();
          if (address !== g.address) begin
            $error("address: expected %0d actual %0d", g.address, address);
            errs++;
          end
          if (success !== g.success) begin
            $error("success: expected %0d actual %0d", g.success, success);
            errs++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        g = '0;
        if (mode == 1'b0) g = allocate_block(longint'(request_bytes));
        else g.success = release_block(longint'(data_address));
        grants_due.push_back(g);
      end
      errors <= errors + errs;
    end
  end
endmodule

FILE: sim/buddy_block_allocator_core_tb.sv
// ---------------------------------------------------------------------------
// buddy block allocator testbench
// directed corner cases then random allocate and free traffic with random
// gaps and stalls on both channels; results checked by the checker module
// ---------------------------------------------------------------------------
module buddy_block_allocator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CYCLE_LIMIT = 3000000;
  localparam int     RANDOM_ITEMS = 1630;

  logic                       clk = 0;
  logic                       rst = 1;
  logic                       in_valid = 0;
  logic                       in_stall;
  logic                       mode = 0;
  logic [bba_pkg::DATA_W-1:0] request_bytes = '0;
  logic [bba_pkg::DATA_W-1:0] data_address = '0;
  logic                       out_valid;
  logic                       out_stall = 0;
  logic [bba_pkg::DATA_W-1:0] address;
  logic                       success;
  int                         errors;
  int                         pending;
  longint                     cycles = 0;
  int                         results_seen = 0;
  logic                       modes_sent[$];
  logic [bba_pkg::DATA_W-1:0] live_blocks[$];
  logic [bba_pkg::DATA_W-1:0] freed_blocks[$];

  always #10 clk = ~clk;

  buddy_block_allocator_core i_dut (.*);

  buddy_block_allocator_core_checker i_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("buddy_block_allocator_core: mismatch");
      $finish;
    end
  end

  // track granted blocks so frees can name real ones
  always @(posedge clk) begin
    logic m;
    if (!rst) begin
      if (in_valid && !in_stall) modes_sent.push_back(mode);
      if (out_valid && !out_stall && modes_sent.size() > 0) begin
        m = modes_sent.pop_front();
        results_seen <= results_seen + 1;
        if (m == 1'b0 && success) live_blocks.push_back(address);
      end
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // receiver: random stalls, repeated long hold-offs, calm stretches
  initial begin
    int n;
    @(negedge rst);
    forever begin
      if (results_seen >= 300 && results_seen < 310) begin
        out_stall <= 1;
        repeat (400) @(posedge clk);
      end
      if ($urandom_range(9) == 0) begin
        out_stall <= 0;
        repeat ($urandom_range(60, 20)) @(posedge clk);
      end
      n = gap_len();
      if (n > 0) begin
        out_stall <= 1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 0;
      @(posedge clk);
    end
  end

  task automatic send(logic m, logic [bba_pkg::DATA_W-1:0] req,
                      logic [bba_pkg::DATA_W-1:0] addr);
    int n;
    mode          <= m;
    request_bytes <= req;
    data_address  <= addr;
    in_valid      <= 1;
    do @(posedge clk); while (in_stall);
    n = gap_len();
    if (n > 0) begin
      in_valid <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic release_live();
    int k;
    logic [bba_pkg::DATA_W-1:0] a;
    k = $urandom_range(live_blocks.size() - 1);
    a = live_blocks[k];
    live_blocks.delete(k);
    freed_blocks.push_back(a);
    if (freed_blocks.size() > 8) void'(freed_blocks.pop_front());
    send(1, bba_pkg::DATA_W'($urandom), a);
  endtask

  function automatic logic [bba_pkg::DATA_W-1:0] pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 70) return bba_pkg::DATA_W'($urandom_range(200, 1));
    if (r < 92) return bba_pkg::DATA_W'($urandom_range(4000, 201));
    return bba_pkg::DATA_W'($urandom_range(65535, 1));
  endfunction

  initial begin
    int r;
    repeat (8) @(posedge clk);
    rst <= 0;

    send(0, 16'd0, 16'hFFFF);
    send(0, 16'hFFFF, 16'd0);
    send(0, 16'd65505, 16'd0);
    send(0, 16'd65504, 16'd0);
    send(0, 16'd1, 16'd0);
    send(1, 16'd0, 16'd32);
    send(0, 16'd1, 16'd0);
    send(1, 16'd0, 16'd0);
    send(1, 16'd0, 16'd31);
    send(1, 16'hFFFF, 16'hFFFF);
    send(1, 16'd0, 16'd33);
    send(1, 16'd0, 16'd96);
    send(0, 16'd32, 16'd0);
    send(0, 16'd33, 16'd0);
    send(0, 16'd1000, 16'd0);
    send(0, 16'd1, 16'd0);
    send(1, 16'd0, 16'd32);
    send(1, 16'd0, 16'd32);
    send(1, 16'd0, 16'd96);
    send(1, 16'd0, 16'd128);
    send(1, 16'd0, 16'd1056);
    send(1, 16'd0, 16'd160);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 800) begin
        in_valid <= 0;
        wait (pending == 0);
        @(posedge clk);
      end
      r = $urandom_range(99);
      if (r < 10) begin
        send($urandom_range(1), bba_pkg::DATA_W'($urandom), bba_pkg::DATA_W'($urandom));
      end else if (r < 14 && freed_blocks.size() > 0) begin
        send(1, bba_pkg::DATA_W'($urandom),
             freed_blocks[$urandom_range(freed_blocks.size() - 1)]);
      end else if (r < 57 && live_blocks.size() > 0) begin
        release_live();
      end else begin
        send(0, pick_size(), bba_pkg::DATA_W'($urandom));
      end
    end
    in_valid <= 0;

    wait (pending == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("buddy_block_allocator_core: match");
    end else begin
      $display("buddy_block_allocator_core: mismatch");
    end
    $finish;
  end
endmodule

FILE: files.f
+incdir+sv
sv/bba_pkg.sv
sv/bba_ram.sv
sv/buddy_block_allocator_core.sv
sim/buddy_block_allocator_core_checker.sv
sim/buddy_block_allocator_core_tb.sv
